/* hdl/kcce_pkg.sv */
// ----------------------------------------------------------------------------
// kcce_pkg
// Shared types, codes and constants for the keyframe cubic channel evaluator.
// ----------------------------------------------------------------------------
package kcce_pkg;

   // Input item actions.
   localparam logic [1:0] ACT_KEY_TIME = 2'd0;
   localparam logic [1:0] ACT_COEF     = 2'd1;
   localparam logic [1:0] ACT_SEEK     = 2'd2;

   // Coefficient vector selects.
   localparam logic [1:0] COEF_A = 2'd0;
   localparam logic [1:0] COEF_B = 2'd1;
   localparam logic [1:0] COEF_C = 2'd2;
   localparam logic [1:0] COEF_D = 2'd3;

   // Register map of the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_MODE  = 2'd1;

   // Fixed widths and constants.
   localparam int KC_W        = 9;
   localparam int BLEND_W     = 17;
   localparam int VW          = 36;   // Horner accumulator width
   localparam int SQRT_STEPS  = 32;   // one result bit per step
   localparam int CNT_W       = 5;
   localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;

   // Quotient bits produced by the shared divider.
   function automatic int div_steps(int frac_bits);
      int r;
      r = (frac_bits + 3 > 17) ? frac_bits + 3 : 17;
      return r;
   endfunction

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_LAST, ST_CLAMP, ST_RD_NEXT, ST_FWD, ST_RD_SEG, ST_BACK,
      ST_RD_END, ST_GET_END, ST_BDIV, ST_BLEND, ST_RD_COEF, ST_COEF, ST_MUL,
      ST_ADD, ST_SAT, ST_SQ, ST_ACC, ST_SQRT_INIT, ST_SQRT, ST_HCHK,
      ST_RSETUP, ST_RDIV, ST_RDONE, ST_ZERO, ST_OUT
   } ctrl_state_type;

   // Datapath operations.
   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_RD_LAST, OP_CLAMP, OP_RD_NEXT, OP_FWD, OP_RD_SEG,
      OP_BACK, OP_GET_END, OP_DIV, OP_BLEND, OP_RD_COEF, OP_LOAD_D, OP_MUL,
      OP_ADD, OP_SAT, OP_SQ, OP_ACC, OP_SQRT_INIT, OP_SQRT, OP_RSETUP,
      OP_RDONE, OP_ZERO, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] lane;
      logic [1:0] vsel;
   } dp_cmd_type;

   typedef struct packed {
      logic fwd_go;
      logic back_go;
      logic rot_mode;
      logic h_zero;
      logic out_free;
   } dp_status_type;

endpackage

/* hdl/kcce_ram.sv */
// ----------------------------------------------------------------------------
// kcce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kcce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kcce_dp.sv */
// ----------------------------------------------------------------------------
// kcce_dp
// Datapath: key tables, segment walk, shared divider, Horner unit, square
// root and the result register.
// ----------------------------------------------------------------------------
module kcce_dp #(
   parameter int MAX_KEYS  = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kcce_pkg::dp_cmd_type          cmd,
   output kcce_pkg::dp_status_type       sts,
   input  logic [1:0]                    req_action,
   input  logic [7:0]                    req_key_index,
   input  logic [1:0]                    req_coef_select,
   input  logic signed [31:0]            req_value_x,
   input  logic signed [31:0]            req_value_y,
   input  logic signed [31:0]            req_value_z,
   input  logic signed [31:0]            req_value_w,
   input  logic [31:0]                   req_time_value,
   input  logic                          csr_valid,
   input  logic [kcce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_out_z,
   output logic signed [31:0]            rsp_out_w,
   output logic [7:0]                    rsp_segment,
   output logic [kcce_pkg::BLEND_W-1:0]  rsp_blend,
   output logic                          rsp_zero_segment
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int DQ = kcce_pkg::div_steps(FRAC_BITS);
   localparam int DW = (FRAC_BITS + 31 > 48) ? FRAC_BITS + 31 : 48;
   localparam int VW = kcce_pkg::VW;
   localparam int PW = VW + 18;

   function automatic logic [31:0] abs32(logic [31:0] x);
      logic [31:0] r;
      r = x[31] ? (32'd0 - x) : x;
      return r;
   endfunction

   // Configuration registers.
   logic [kcce_pkg::KC_W-1:0] kc_ff;
   logic                      rot_ff;

   // Seek state.
   logic [AW-1:0]             seg_ff;
   logic [31:0]               t_ff;
   logic [31:0]               start_ff;
   logic                      zero_ff;
   logic [kcce_pkg::BLEND_W-1:0] u_ff;

   // Divider.
   logic [31:0]               rem_ff;
   logic [DQ-1:0]             quo_ff;
   logic [31:0]               dvs_ff;

   // Horner and rotation.
   logic signed [VW-1:0]      v_ff [4];
   logic signed [PW-1:0]      prod_ff;
   logic [63:0]               sq_ff;
   logic [63:0]               s_ff;
   logic [63:0]               sr_ff;
   logic [63:0]               res_ff;
   logic [63:0]               bit_ff;

   // Result register.
   logic                      rsp_valid_ff;
   logic [31:0]               out_ff [4];
   logic [7:0]                oseg_ff;
   logic [kcce_pkg::BLEND_W-1:0] oblend_ff;
   logic                      ozero_ff;

   // RAM signals.
   logic                      kt_wr_en;
   logic                      kt_rd_en;
   logic [AW-1:0]             kt_rd_addr;
   logic [31:0]               kt_rd;
   logic                      cf_wr_en;
   logic                      cf_rd_en;
   logic [127:0]              cf_rd;
   logic                      key_ok;

   // Combinational helpers.
   logic [CW-1:0]             n_w;
   logic [AW-1:0]             nm1_w;
   logic [AW-1:0]             nm2_w;
   logic [31:0]               dur_w;
   logic [31:0]               num_w;
   logic [DW-1:0]             bdiv_w;
   logic [31:0]               m_w;
   logic [DW-1:0]             rdiv_w;
   logic [32:0]               trial_w;
   logic                      ge_w;
   logic signed [PW-1:0]      rnd_w;
   logic signed [31:0]        coef_w;
   logic [63:0]               stry_w;
   logic [31:0]               h_w;

   // Keys in use, clamped to the table.
   always_comb begin
      if (kc_ff < 9'd2) begin
         n_w = CW'(2);
      end else if (32'(kc_ff) > MAX_KEYS) begin
         n_w = CW'(MAX_KEYS);
      end else begin
         n_w = CW'(kc_ff);
      end
   end
   assign nm1_w = AW'(n_w - CW'(1));
   assign nm2_w = AW'(n_w - CW'(2));

   // Table writes and reads.
   assign key_ok   = 32'(req_key_index) < MAX_KEYS;
   assign kt_wr_en = (cmd.op == kcce_pkg::OP_LOAD) && (req_action == kcce_pkg::ACT_KEY_TIME)
                     && key_ok;
   assign cf_wr_en = (cmd.op == kcce_pkg::OP_LOAD) && (req_action == kcce_pkg::ACT_COEF)
                     && key_ok;
   assign kt_rd_en = (cmd.op == kcce_pkg::OP_RD_LAST) || (cmd.op == kcce_pkg::OP_RD_NEXT)
                     || (cmd.op == kcce_pkg::OP_RD_SEG);
   assign cf_rd_en = (cmd.op == kcce_pkg::OP_RD_COEF);

   always_comb begin
      unique case (cmd.op)
         kcce_pkg::OP_RD_LAST: kt_rd_addr = nm1_w;
         kcce_pkg::OP_RD_NEXT: kt_rd_addr = seg_ff + AW'(1);
         default:              kt_rd_addr = seg_ff;
      endcase
   end

   kcce_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_key_times (
      .clock   (clock),
      .wr_en   (kt_wr_en),
      .wr_addr (AW'(req_key_index)),
      .wr_data (req_time_value),
      .rd_en   (kt_rd_en),
      .rd_addr (kt_rd_addr),
      .rd_data (kt_rd)
   );

   kcce_ram #(.WIDTH(128), .DEPTH(MAX_KEYS * 4)) u_coef_store (
      .clock   (clock),
      .wr_en   (cf_wr_en),
      .wr_addr ({AW'(req_key_index), req_coef_select}),
      .wr_data ({req_value_w, req_value_z, req_value_y, req_value_x}),
      .rd_en   (cf_rd_en),
      .rd_addr ({seg_ff, cmd.vsel}),
      .rd_data (cf_rd)
   );

   // Blend dividend: offset into the segment, clamped to its duration.
   always_comb begin
      dur_w = kt_rd - start_ff;
      num_w = (t_ff > start_ff) ? (t_ff - start_ff) : 32'd0;
      if (num_w > dur_w) begin
         num_w = dur_w;
      end
      bdiv_w = DW'({num_w, 16'd0});
   end

   // Rotation dividend for the selected lane.
   assign h_w    = res_ff[31:0];
   assign m_w    = abs32(v_ff[cmd.lane][31:0]);
   assign rdiv_w = (DW'(m_w) << (FRAC_BITS - 1)) + DW'(h_w >> 1);

   // One restoring divide step.
   assign trial_w = {rem_ff, quo_ff[DQ-1]};
   assign ge_w    = trial_w >= {1'b0, dvs_ff};

   // Horner rounding: nearest, ties toward plus infinity.
   assign rnd_w  = (prod_ff + PW'(32768)) >>> 16;
   assign coef_w = $signed(cf_rd[32*cmd.lane +: 32]);

   assign stry_w = res_ff + bit_ff;

   // Status to the controller.
   assign sts.fwd_go   = (seg_ff < nm2_w) && (t_ff > kt_rd);
   assign sts.back_go  = (seg_ff != '0) && (t_ff < kt_rd);
   assign sts.rot_mode = rot_ff;
   assign sts.h_zero   = (res_ff == 64'd0);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff        <= 9'd2;
         rot_ff       <= 1'b0;
         seg_ff       <= '0;
         u_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == kcce_pkg::CSR_KEY_COUNT) begin
            kc_ff <= csr_data[kcce_pkg::KC_W-1:0];
         end
         if (csr_valid && csr_index == kcce_pkg::CSR_ROT_MODE) begin
            rot_ff <= csr_data[0];
         end
         if (cmd.op == kcce_pkg::OP_LOAD && req_action == kcce_pkg::ACT_SEEK
             && seg_ff > nm2_w) begin
            seg_ff <= nm2_w;
         end
         if (cmd.op == kcce_pkg::OP_FWD && sts.fwd_go) begin
            seg_ff <= seg_ff + AW'(1);
         end
         if (cmd.op == kcce_pkg::OP_BACK && sts.back_go) begin
            seg_ff <= seg_ff - AW'(1);
         end
         if (cmd.op == kcce_pkg::OP_BLEND) begin
            if (zero_ff) begin
               u_ff <= '0;
            end else if (quo_ff > DQ'(kcce_pkg::BLEND_ONE)) begin
               u_ff <= kcce_pkg::BLEND_ONE;
            end else begin
               u_ff <= quo_ff[kcce_pkg::BLEND_W-1:0];
            end
         end
         if (cmd.op == kcce_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         kcce_pkg::OP_LOAD: begin
            t_ff <= req_time_value;
         end
         kcce_pkg::OP_CLAMP: begin
            if (t_ff > kt_rd) begin
               t_ff <= kt_rd;
            end
         end
         kcce_pkg::OP_BACK: begin
            if (!sts.back_go) begin
               start_ff <= kt_rd;
            end
         end
         kcce_pkg::OP_GET_END: begin
            zero_ff <= (kt_rd <= start_ff);
            rem_ff  <= 32'(bdiv_w >> DQ);
            quo_ff  <= bdiv_w[DQ-1:0];
            dvs_ff  <= dur_w;
         end
         kcce_pkg::OP_RSETUP: begin
            rem_ff <= 32'(rdiv_w >> DQ);
            quo_ff <= rdiv_w[DQ-1:0];
            dvs_ff <= h_w;
         end
         kcce_pkg::OP_DIV: begin
            rem_ff <= ge_w ? 32'(trial_w - {1'b0, dvs_ff}) : trial_w[31:0];
            quo_ff <= {quo_ff[DQ-2:0], ge_w};
         end
         kcce_pkg::OP_LOAD_D: begin
            for (int c = 0; c < 4; c++) begin
               v_ff[c] <= VW'($signed(cf_rd[32*c +: 32]));
            end
         end
         kcce_pkg::OP_MUL: begin
            prod_ff <= v_ff[cmd.lane] * $signed({1'b0, u_ff});
         end
         kcce_pkg::OP_ADD: begin
            v_ff[cmd.lane] <= $signed(rnd_w[VW-1:0]) + VW'(coef_w);
         end
         kcce_pkg::OP_SAT: begin
            // Saturate each lane to 32 signed bits.
            for (int c = 0; c < 4; c++) begin
               if (!(&v_ff[c][VW-1:31]) && (|v_ff[c][VW-1:31])) begin
                  v_ff[c] <= v_ff[c][VW-1] ? VW'(-64'sd2147483648) : VW'(64'sd2147483647);
               end
            end
            s_ff <= '0;
         end
         kcce_pkg::OP_SQ: begin
            sq_ff <= m_w * m_w;
         end
         kcce_pkg::OP_ACC: begin
            s_ff <= s_ff + (sq_ff >> 2);
         end
         kcce_pkg::OP_SQRT_INIT: begin
            sr_ff  <= s_ff;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         kcce_pkg::OP_SQRT: begin
            if (sr_ff >= stry_w) begin
               sr_ff  <= sr_ff - stry_w;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         kcce_pkg::OP_RDONE: begin
            v_ff[cmd.lane] <= v_ff[cmd.lane][31] ? (VW'(0) - VW'(quo_ff)) : VW'(quo_ff);
         end
         kcce_pkg::OP_ZERO: begin
            for (int c = 0; c < 4; c++) begin
               v_ff[c] <= '0;
            end
         end
         kcce_pkg::OP_OUT: begin
            for (int c = 0; c < 4; c++) begin
               out_ff[c] <= v_ff[c][31:0];
            end
            oseg_ff   <= 8'(seg_ff);
            oblend_ff <= u_ff;
            ozero_ff  <= zero_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = out_ff[0];
   assign rsp_out_y        = out_ff[1];
   assign rsp_out_z        = out_ff[2];
   assign rsp_out_w        = out_ff[3];
   assign rsp_segment      = oseg_ff;
   assign rsp_blend        = oblend_ff;
   assign rsp_zero_segment = ozero_ff;

endmodule

/* hdl/kcce_ctrl.sv */
// ----------------------------------------------------------------------------
// kcce_ctrl
// Controller: sequences the seek, divide, Horner and rotation steps.
// ----------------------------------------------------------------------------
module kcce_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_action,
   output logic                     req_stall,
   input  kcce_pkg::dp_status_type  sts,
   output kcce_pkg::dp_cmd_type     cmd
);

   localparam int DQ = kcce_pkg::div_steps(FRAC_BITS);
   localparam int CW = kcce_pkg::CNT_W;

   kcce_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0]    lane_ff, lane_in;
   logic [1:0]    vsel_ff, vsel_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcce_pkg::ST_IDLE;
         lane_ff  <= '0;
         vsel_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         vsel_ff  <= vsel_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      lane_in   = lane_ff;
      vsel_in   = vsel_ff;
      cnt_in    = cnt_ff;
      cmd.op    = kcce_pkg::OP_NONE;
      cmd.lane  = lane_ff;
      cmd.vsel  = vsel_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         kcce_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = kcce_pkg::OP_LOAD;
               if (req_action == kcce_pkg::ACT_SEEK) begin
                  state_in = kcce_pkg::ST_RD_LAST;
               end
            end
         end
         kcce_pkg::ST_RD_LAST: begin
            cmd.op   = kcce_pkg::OP_RD_LAST;
            state_in = kcce_pkg::ST_CLAMP;
         end
         kcce_pkg::ST_CLAMP: begin
            cmd.op   = kcce_pkg::OP_CLAMP;
            state_in = kcce_pkg::ST_RD_NEXT;
         end
         kcce_pkg::ST_RD_NEXT: begin
            cmd.op   = kcce_pkg::OP_RD_NEXT;
            state_in = kcce_pkg::ST_FWD;
         end
         kcce_pkg::ST_FWD: begin
            cmd.op   = kcce_pkg::OP_FWD;
            state_in = sts.fwd_go ? kcce_pkg::ST_RD_NEXT : kcce_pkg::ST_RD_SEG;
         end
         kcce_pkg::ST_RD_SEG: begin
            cmd.op   = kcce_pkg::OP_RD_SEG;
            state_in = kcce_pkg::ST_BACK;
         end
         kcce_pkg::ST_BACK: begin
            cmd.op   = kcce_pkg::OP_BACK;
            state_in = sts.back_go ? kcce_pkg::ST_RD_SEG : kcce_pkg::ST_RD_END;
         end
         kcce_pkg::ST_RD_END: begin
            cmd.op   = kcce_pkg::OP_RD_NEXT;
            state_in = kcce_pkg::ST_GET_END;
         end
         kcce_pkg::ST_GET_END: begin
            cmd.op   = kcce_pkg::OP_GET_END;
            cnt_in   = '0;
            state_in = kcce_pkg::ST_BDIV;
         end
         kcce_pkg::ST_BDIV: begin
            cmd.op = kcce_pkg::OP_DIV;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DQ - 1)) begin
               state_in = kcce_pkg::ST_BLEND;
            end
         end
         kcce_pkg::ST_BLEND: begin
            cmd.op   = kcce_pkg::OP_BLEND;
            vsel_in  = kcce_pkg::COEF_D;
            state_in = kcce_pkg::ST_RD_COEF;
         end
         kcce_pkg::ST_RD_COEF: begin
            cmd.op   = kcce_pkg::OP_RD_COEF;
            state_in = kcce_pkg::ST_COEF;
         end
         kcce_pkg::ST_COEF: begin
            if (vsel_ff == kcce_pkg::COEF_D) begin
               cmd.op   = kcce_pkg::OP_LOAD_D;
               vsel_in  = kcce_pkg::COEF_C;
               state_in = kcce_pkg::ST_RD_COEF;
            end else begin
               lane_in  = '0;
               state_in = kcce_pkg::ST_MUL;
            end
         end
         kcce_pkg::ST_MUL: begin
            cmd.op   = kcce_pkg::OP_MUL;
            state_in = kcce_pkg::ST_ADD;
         end
         kcce_pkg::ST_ADD: begin
            cmd.op = kcce_pkg::OP_ADD;
            if (lane_ff == 2'd3) begin
               if (vsel_ff == kcce_pkg::COEF_A) begin
                  state_in = kcce_pkg::ST_SAT;
               end else begin
                  vsel_in  = vsel_ff - 2'd1;
                  state_in = kcce_pkg::ST_RD_COEF;
               end
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = kcce_pkg::ST_MUL;
            end
         end
         kcce_pkg::ST_SAT: begin
            cmd.op   = kcce_pkg::OP_SAT;
            lane_in  = '0;
            state_in = sts.rot_mode ? kcce_pkg::ST_SQ : kcce_pkg::ST_OUT;
         end
         kcce_pkg::ST_SQ: begin
            cmd.op   = kcce_pkg::OP_SQ;
            state_in = kcce_pkg::ST_ACC;
         end
         kcce_pkg::ST_ACC: begin
            cmd.op = kcce_pkg::OP_ACC;
            if (lane_ff == 2'd3) begin
               state_in = kcce_pkg::ST_SQRT_INIT;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = kcce_pkg::ST_SQ;
            end
         end
         kcce_pkg::ST_SQRT_INIT: begin
            cmd.op   = kcce_pkg::OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = kcce_pkg::ST_SQRT;
         end
         kcce_pkg::ST_SQRT: begin
            cmd.op = kcce_pkg::OP_SQRT;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(kcce_pkg::SQRT_STEPS - 1)) begin
               state_in = kcce_pkg::ST_HCHK;
            end
         end
         kcce_pkg::ST_HCHK: begin
            lane_in  = '0;
            state_in = sts.h_zero ? kcce_pkg::ST_ZERO : kcce_pkg::ST_RSETUP;
         end
         kcce_pkg::ST_RSETUP: begin
            cmd.op   = kcce_pkg::OP_RSETUP;
            cnt_in   = '0;
            state_in = kcce_pkg::ST_RDIV;
         end
         kcce_pkg::ST_RDIV: begin
            cmd.op = kcce_pkg::OP_DIV;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DQ - 1)) begin
               state_in = kcce_pkg::ST_RDONE;
            end
         end
         kcce_pkg::ST_RDONE: begin
            cmd.op = kcce_pkg::OP_RDONE;
            if (lane_ff == 2'd3) begin
               state_in = kcce_pkg::ST_OUT;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = kcce_pkg::ST_RSETUP;
            end
         end
         kcce_pkg::ST_ZERO: begin
            cmd.op   = kcce_pkg::OP_ZERO;
            state_in = kcce_pkg::ST_OUT;
         end
         kcce_pkg::ST_OUT: begin
            if (sts.out_free) begin
               cmd.op   = kcce_pkg::OP_OUT;
               state_in = kcce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kcce_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/keyframe_cubic_channel_eval_top.sv */
// A seek reads and clamps its time, walks forward and back to its segment, divides
// for the blend with DQ = max(17, FRAC_BITS + 3) quotient bits and runs Horner over
// the lanes; the next beat can be taken in the same cycle that the result shows.
// Rotation mode adds a sum of squares, a square root and a divide per lane; a stalled
// result beat holds the block. The block takes one item at a time. Reset clears control
// state, key_count to 2 and rotation_mode to 0; the tables hold unknown data until written.
// ----------------------------------------------------------------------------
// keyframe_cubic_channel_eval_top
// Cubic keyframe channel evaluator: key tables, segment seek, Horner, rotation.
// ----------------------------------------------------------------------------
module keyframe_cubic_channel_eval_top #(
   parameter int MAX_KEYS  = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [7:0]                     req_key_index,
   input  logic [1:0]                     req_coef_select,
   input  logic signed [31:0]             req_value_x,
   input  logic signed [31:0]             req_value_y,
   input  logic signed [31:0]             req_value_z,
   input  logic signed [31:0]             req_value_w,
   input  logic [31:0]                    req_time_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_out_x,
   output logic signed [31:0]             rsp_out_y,
   output logic signed [31:0]             rsp_out_z,
   output logic signed [31:0]             rsp_out_w,
   output logic [7:0]                     rsp_segment,
   output logic [kcce_pkg::BLEND_W-1:0]   rsp_blend,
   output logic                           rsp_zero_segment,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kcce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);

   kcce_pkg::dp_cmd_type    cmd;
   kcce_pkg::dp_status_type sts;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   kcce_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   kcce_dp #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_key_index    (req_key_index),
      .req_coef_select  (req_coef_select),
      .req_value_x      (req_value_x),
      .req_value_y      (req_value_y),
      .req_value_z      (req_value_z),
      .req_value_w      (req_value_w),
      .req_time_value   (req_time_value),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_w        (rsp_out_w),
      .rsp_segment      (rsp_segment),
      .rsp_blend        (rsp_blend),
      .rsp_zero_segment (rsp_zero_segment)
   );

endmodule

/* hdl/kcce_checker.sv */
// ----------------------------------------------------------------------------
// kcce_checker
// Port-level checks for the keyframe cubic channel evaluator.
// ----------------------------------------------------------------------------
module kcce_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [1:0]                     req_action,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [31:0]             rsp_out_x,
   input logic [kcce_pkg::BLEND_W-1:0]   rsp_blend,
   input logic                           rsp_zero_segment,
   input logic                           csr_ready
);

   // A stalled result beat stays and holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_stall)) |-> (rsp_valid && $stable(rsp_out_x)))
      else $error("stalled result beat changed");

   // A zero-length segment always reports a zero blend.
   a_zero_blend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_segment) |-> (rsp_blend == '0))
      else $error("zero segment with nonzero blend");

   // The blend never exceeds one.
   a_blend_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_blend <= kcce_pkg::BLEND_ONE))
      else $error("blend above one");

   // A seek occupies the block on the following cycle.
   a_seek_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == kcce_pkg::ACT_SEEK) |=> req_stall)
      else $error("seek accepted without going busy");

   // The register port never pushes back.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind keyframe_cubic_channel_eval_top kcce_checker u_kcce_checker (.*);

/* sim/tb_keyframe_cubic_channel_eval_top.sv */
// ----------------------------------------------------------------------------
// tb_keyframe_cubic_channel_eval_top
// Self-checking bench for the keyframe cubic channel evaluator. Key times and
// coefficient vectors are loaded, then seeks are sent with random gaps and
// result stalls. A scoreboard class mirrors the channel tables and predicts
// each result: segment walk, blend, Horner evaluation and rotation scaling.
// ----------------------------------------------------------------------------
module tb_keyframe_cubic_channel_eval_top;

   // Action code that the block ignores.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // On the full table only the keys below SPARSE_LO and from SPARSE_HI on get coefficient vectors.
   localparam int SPARSE_LO = 16;
   localparam int SPARSE_HI = 240;

   // Predicted result of one seek.
   typedef struct {
      logic signed [31:0] comp[4];
      logic [7:0]         seg;
      logic [16:0]        blend;
      logic               zero;
   } eval_result_type;

   // Scoreboard: keeps a mirror of the channel and a queue of pending results.
   class channel_scoreboard;
      logic [31:0]     key_time_tbl[256];
      logic [31:0]     coef_tbl[4096];
      int unsigned     kept_seg;
      int unsigned     keys_in_use;
      bit              rot_on;
      eval_result_type pending[$];
      int              mismatches;

      function new();
         foreach (key_time_tbl[i]) key_time_tbl[i] = 0;
         foreach (coef_tbl[i]) coef_tbl[i] = 0;
         kept_seg = 0;
         keys_in_use = 2;
         rot_on = 0;
         mismatches = 0;
      endfunction

      // Round a Q32 product back to Q16, ties toward plus infinity.
      function longint round_q16(longint v);
         return (v + 32768) >>> 16;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned int_sqrt(longint unsigned s);
         longint unsigned res, bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > s) bit_v >>= 2;
         while (bit_v != 0) begin
            if (s >= res + bit_v) begin
               s -= res + bit_v;
               res = (res >> 1) + bit_v;
            end else begin
               res >>= 1;
            end
            bit_v >>= 2;
         end
         return res;
      endfunction

      // Note one accepted input beat; seeks queue a prediction.
      function void note_input(logic [1:0] act, logic [7:0] key, logic [1:0] sel,
                               logic [31:0] vals[4], logic [31:0] t);
         int unsigned n, seg, start, stop, u;
         longint unsigned dur, num, s, h, m;
         longint r[4];
         longint v;
         eval_result_type e;
         if (act == kcce_pkg::ACT_KEY_TIME) begin
            key_time_tbl[key] = t;
            return;
         end
         if (act == kcce_pkg::ACT_COEF) begin
            for (int c = 0; c < 4; c++) coef_tbl[key * 16 + sel * 4 + c] = vals[c];
            return;
         end
         if (act != kcce_pkg::ACT_SEEK) return;
         n = keys_in_use;
         if (n < 2) n = 2;
         if (n > 256) n = 256;
         seg = kept_seg;
         if (seg > n - 2) seg = n - 2;
         if (t > key_time_tbl[n - 1]) t = key_time_tbl[n - 1];
         while (seg < n - 2 && t > key_time_tbl[seg + 1]) seg++;
         while (seg > 0 && t < key_time_tbl[seg]) seg--;
         start = key_time_tbl[seg];
         stop = key_time_tbl[seg + 1];
         e.zero = 0;
         if (stop <= start) begin
            e.zero = 1;
            u = 0;
         end else begin
            dur = stop - start;
            num = (t > start) ? t - start : 0;
            if (num > dur) num = dur;
            u = 32'((num << 16) / dur);
            if (u > 65536) u = 65536;
         end
         kept_seg = seg;
         for (int c = 0; c < 4; c++) begin
            v = longint'(signed'(coef_tbl[seg * 16 + 12 + c]));
            v = round_q16(v * u) + longint'(signed'(coef_tbl[seg * 16 + 8 + c]));
            v = round_q16(v * u) + longint'(signed'(coef_tbl[seg * 16 + 4 + c]));
            v = round_q16(v * u) + longint'(signed'(coef_tbl[seg * 16 + c]));
            r[c] = sat32(v);
         end
         // Rotation mode scales the vector to unit length.
         if (rot_on) begin
            s = 0;
            for (int c = 0; c < 4; c++) begin
               m = r[c] < 0 ? -r[c] : r[c];
               s += (m * m) >> 2;
            end
            h = int_sqrt(s);
            for (int c = 0; c < 4; c++) begin
               if (h == 0) begin
                  r[c] = 0;
               end else begin
                  m = r[c] < 0 ? -r[c] : r[c];
                  v = ((m << 15) + (h >> 1)) / h;
                  r[c] = sat32(r[c] < 0 ? -v : v);
               end
            end
         end
         for (int c = 0; c < 4; c++) e.comp[c] = r[c][31:0];
         e.seg = seg[7:0];
         e.blend = u[16:0];
         pending.push_back(e);
      endfunction

      // Compare one result beat with the oldest prediction.
      function void check_result(logic signed [31:0] got[4], logic [7:0] seg,
                                 logic [16:0] blend, logic zero);
         eval_result_type e;
         bit bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat, seg %0d", seg);
            return;
         end
         e = pending.pop_front();
         bad = (seg !== e.seg) || (blend !== e.blend) || (zero !== e.zero);
         for (int c = 0; c < 4; c++) if (got[c] !== e.comp[c]) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch: exp %h %h %h %h seg %0d blend %0d z %0b, ",
                         "got %h %h %h %h seg %0d blend %0d z %0b"},
                        e.comp[0], e.comp[1], e.comp[2], e.comp[3], e.seg, e.blend,
                        e.zero, got[0], got[1], got[2], got[3], seg, blend, zero);
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [1:0]                     req_action;
   logic [7:0]                     req_key_index;
   logic [1:0]                     req_coef_select;
   logic signed [31:0]             req_value_x, req_value_y, req_value_z, req_value_w;
   logic [31:0]                    req_time_value;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic signed [31:0]             rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic [7:0]                     rsp_segment;
   logic [kcce_pkg::BLEND_W-1:0]   rsp_blend;
   logic                           rsp_zero_segment;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [kcce_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                    csr_data;

   channel_scoreboard sb;
   int unsigned       cycle_count;

   keyframe_cubic_channel_eval_top u_top (.*);

   // Clock.
   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stalls, checking at the rising edge.
   int rsp_wait;
   always @(posedge clock) begin
      logic signed [31:0] got[4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got[0] = rsp_out_x;
         got[1] = rsp_out_y;
         got[2] = rsp_out_z;
         got[3] = rsp_out_w;
         sb.check_result(got, rsp_segment, rsp_blend, rsp_zero_segment);
      end
   end
   initial begin
      rsp_stall = 1;
      forever begin
         @(negedge clock);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if (rsp_valid) rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         end
      end
   end

   // Write one register while the block is idle.
   task automatic write_csr(logic [kcce_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == kcce_pkg::CSR_KEY_COUNT) sb.keys_in_use = 32'(data[8:0]);
      else if (idx == kcce_pkg::CSR_ROT_MODE) sb.rot_on = data[0];
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Send one input beat after a random gap. Valid stays high after the beat
   // until the next beat or an idle phase lowers it.
   task automatic send_item(logic [1:0] act, logic [7:0] key, logic [1:0] sel,
                            logic [31:0] vals[4], logic [31:0] t, bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_key_index <= key;
      req_coef_select <= sel;
      req_value_x <= vals[0];
      req_value_y <= vals[1];
      req_value_z <= vals[2];
      req_value_w <= vals[3];
      req_time_value <= t;
      do @(posedge clock); while (req_stall);
      sb.note_input(act, key, sel, vals, t);
      @(negedge clock);
   endtask

   // Hold the input idle until every expected result has come.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 131072) - 65536;
         default: return $urandom;
      endcase
   endfunction

   // Load sorted key times for keys 0..n-1 and random coefficients for the
   // keys below coef_lo and from coef_hi on.
   task automatic load_channel(int n, bit with_dups, int coef_lo, int coef_hi);
      logic [31:0] vals[4];
      logic [31:0] t;
      t = $urandom_range(0, 1000);
      foreach (vals[c]) vals[c] = 0;
      for (int k = 0; k < n; k++) begin
         send_item(kcce_pkg::ACT_KEY_TIME, k[7:0], kcce_pkg::COEF_A, vals, t, 0);
         if (!(with_dups && $urandom_range(0, 3) == 0))
            t = t + $urandom_range(1, 200000);
         if (k < coef_lo || k >= coef_hi) begin
            for (int s = 0; s < 4; s++) begin
               foreach (vals[c]) vals[c] = rand_coef();
               send_item(kcce_pkg::ACT_COEF, k[7:0], s[1:0], vals, 0, 0);
            end
         end
      end
   endtask

   task automatic random_seek(int n);
      logic [31:0] vals[4];
      logic [31:0] lo, hi, t;
      foreach (vals[c]) vals[c] = $urandom;
      lo = sb.key_time_tbl[0];
      hi = sb.key_time_tbl[n - 1];
      case ($urandom_range(0, 7))
         0: t = $urandom;
         1: t = 32'hFFFF_FFFF;
         2: t = 32'd0;
         3: t = sb.key_time_tbl[$urandom_range(0, n - 1)];
         default: t = lo + $urandom_range(0, hi - lo);
      endcase
      send_item(kcce_pkg::ACT_SEEK, 8'($urandom), 2'($urandom), vals, t, 0);
   endtask

   // Seeks on the full table that only land in segments with coefficients.
   task automatic sparse_seek();
      logic [31:0] vals[4];
      logic [31:0] lo_top, hi_base, t;
      foreach (vals[c]) vals[c] = $urandom;
      lo_top = sb.key_time_tbl[SPARSE_LO - 1];
      hi_base = sb.key_time_tbl[SPARSE_HI + 1];
      case ($urandom_range(0, 4))
         0: t = $urandom_range(0, lo_top);
         1: t = hi_base + $urandom_range(0, 32'hFFFF_FFFF - hi_base);
         2: t = 32'hFFFF_FFFF;
         3: t = sb.key_time_tbl[$urandom_range(0, SPARSE_LO - 1)];
         default: t = sb.key_time_tbl[$urandom_range(SPARSE_HI + 1, 255)];
      endcase
      send_item(kcce_pkg::ACT_SEEK, 8'($urandom), 2'($urandom), vals, t, 0);
   endtask

   initial begin
      logic [31:0] vals[4];
      int n;
      sb = new();
      cycle_count = 0;
      rsp_wait = 0;
      req_valid = 0;
      req_action = kcce_pkg::ACT_KEY_TIME;
      req_key_index = 0;
      req_coef_select = kcce_pkg::COEF_A;
      req_value_x = 0;
      req_value_y = 0;
      req_value_z = 0;
      req_value_w = 0;
      req_time_value = 0;
      csr_valid = 0;
      csr_index = kcce_pkg::CSR_KEY_COUNT;
      csr_data = 0;
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: two keys at extremes, zero-length segment, unused action.
      vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000};
      send_item(kcce_pkg::ACT_KEY_TIME, 0, kcce_pkg::COEF_A, vals, 0, 0);
      send_item(kcce_pkg::ACT_KEY_TIME, 1, kcce_pkg::COEF_A, vals, 32'hFFFF_FFFF, 0);
      for (int s = 0; s < 4; s++) send_item(kcce_pkg::ACT_COEF, 0, s[1:0], vals, 0, 0);
      send_item(kcce_pkg::ACT_SEEK, 0, kcce_pkg::COEF_A, vals, 32'h8000_0000, 0);
      send_item(kcce_pkg::ACT_SEEK, 0, kcce_pkg::COEF_A, vals, 32'hFFFF_FFFF, 1);
      send_item(kcce_pkg::ACT_SEEK, 0, kcce_pkg::COEF_A, vals, 0, 1);
      send_item(ACT_UNUSED, 8'hFF, kcce_pkg::COEF_D, vals, 32'hFFFF_FFFF, 0);
      send_item(kcce_pkg::ACT_KEY_TIME, 1, kcce_pkg::COEF_A, vals, 0, 0);
      send_item(kcce_pkg::ACT_SEEK, 0, kcce_pkg::COEF_A, vals, 5, 0);
      drain();
      write_csr(kcce_pkg::CSR_ROT_MODE, 1);
      send_item(kcce_pkg::ACT_SEEK, 0, kcce_pkg::COEF_A, vals, 0, 0);
      vals = '{0, 0, 0, 0};
      for (int s = 0; s < 4; s++) send_item(kcce_pkg::ACT_COEF, 0, s[1:0], vals, 0, 0);
      send_item(kcce_pkg::ACT_SEEK, 0, kcce_pkg::COEF_A, vals, 0, 0);
      drain();

      // Random phases over several key counts and both modes.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: n = 2;
            1: n = 256;
            2: n = 5;
            3: n = 3;
            default: n = $urandom_range(2, 20);
         endcase
         write_csr(kcce_pkg::CSR_ROT_MODE, phase[0]);
         if (phase == 1) load_channel(n, 0, SPARSE_LO, SPARSE_HI);
         else load_channel(n, phase >= 4, n, n);
         // Out-of-range counts act as the nearest bound; only use them on full loads.
         if (n == 256 && phase == 1) write_csr(kcce_pkg::CSR_KEY_COUNT, 9'h1FF);
         else write_csr(kcce_pkg::CSR_KEY_COUNT, n);
         for (int i = 0; i < (phase == 1 ? 60 : 100); i++) begin
            if (phase == 1) sparse_seek();
            else random_seek(n);
         end
         drain();
      end
      // Count below two acts as two.
      write_csr(kcce_pkg::CSR_KEY_COUNT, 0);
      for (int i = 0; i < 10; i++) random_seek(2);
      drain();

      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
